// File: hdl/qrs_pkg.sv
// Shared constants for the quadratic root selector.
package qrs_pkg;

  // Default word and fraction widths of the signed fixed-point values.
  localparam int QRS_WORD_BITS = 32;
  localparam int QRS_FRAC_BITS = 16;

endpackage

// File: hdl/quadratic_root_select.sv
// Top level of the quadratic root selector: products, root and divider chains.
//
//   channel  ports                                      handshake
//   input    in_coef_quad/lin/const, in_unit_interval_  start & !busy
//            mode, in_fallback_root
//   result   out_root_value, out_ok                     out_valid, one cycle
//
// A new beat is taken in every cycle; busy is always low.
// A beat passes through the stage one and two registers, the WORD_BITS+1 square root cells,
// the stage three register, the WORD_BITS+FRAC_BITS+2 divider cells and the result register.
// Reset clears only the valid bits along the chains.
// The receiver cannot stall, so results are never held back.
module quadratic_root_select #(
  parameter int WORD_BITS = qrs_pkg::QRS_WORD_BITS,
  parameter int FRAC_BITS = qrs_pkg::QRS_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [WORD_BITS-1:0] in_coef_quad,
  input  logic signed [WORD_BITS-1:0] in_coef_lin,
  input  logic signed [WORD_BITS-1:0] in_coef_const,
  input  logic                        in_unit_interval_mode,
  input  logic signed [WORD_BITS-1:0] in_fallback_root,
  output logic                        out_valid,
  output logic signed [WORD_BITS-1:0] out_root_value,
  output logic                        out_ok
);

  import qrs_pkg::*;

  localparam int W     = WORD_BITS;
  localparam int SW    = W + 1;
  localparam int RW    = 2 * SW;
  localparam int DW    = W + 1;
  localparam int NW    = W + 2 + FRAC_BITS;
  localparam int STAG  = 2 + W + W + 1 + DW;
  localparam int DTAG  = 2 + W + 2;

  assign busy = 1'b0;

  // Magnitudes of the input words.
  logic [W-1:0] mag_a;
  logic [W-1:0] mag_b;
  logic [W-1:0] mag_c;

  always_comb begin
    mag_a = in_coef_quad[W-1] ? (~in_coef_quad + 1'b1) : in_coef_quad;
    mag_b = in_coef_lin[W-1] ? (~in_coef_lin + 1'b1) : in_coef_lin;
    mag_c = in_coef_const[W-1] ? (~in_coef_const + 1'b1) : in_coef_const;
  end

  // Stage one: the two products of the discriminant.
  logic             s1_v_r;
  logic [2*W-1:0]   s1_bb_r;
  logic [2*W-1:0]   s1_ac_r;
  logic             s1_acneg_r;
  logic             s1_anz_r;
  logic             s1_aneg_r;
  logic [W-1:0]     s1_b_r;
  logic [DW-1:0]    s1_den_r;
  logic             s1_unit_r;
  logic [W-1:0]     s1_fb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    s1_bb_r    <= {{W{1'b0}}, mag_b} * {{W{1'b0}}, mag_b};
    s1_ac_r    <= {{W{1'b0}}, mag_a} * {{W{1'b0}}, mag_c};
    s1_acneg_r <= (in_coef_quad[W-1] != in_coef_const[W-1]) && (in_coef_const != '0);
    s1_anz_r   <= (in_coef_quad != '0);
    s1_aneg_r  <= in_coef_quad[W-1];
    s1_b_r     <= in_coef_lin;
    s1_den_r   <= {mag_a, 1'b0};
    s1_unit_r  <= in_unit_interval_mode;
    s1_fb_r    <= in_fallback_root;
  end

  // Stage two: discriminant and its sign test.
  logic [RW-1:0] bb_x;
  logic [RW-1:0] ac4_x;
  logic          dpos;

  always_comb begin
    bb_x  = {2'b00, s1_bb_r};
    ac4_x = {s1_ac_r, 2'b00};
    dpos  = s1_acneg_r || (bb_x > ac4_x);
  end

  logic            s2_v_r;
  logic [RW-1:0]   s2_rad_r;
  logic [STAG-1:0] s2_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_rad_r <= s1_acneg_r ? (bb_x + ac4_x) : (bb_x - ac4_x);
    s2_tag_r <= {s1_anz_r && dpos, s1_unit_r, s1_fb_r, s1_b_r, s1_aneg_r, s1_den_r};
  end

  // Square root chain.
  logic            sq_v   [0:SW];
  logic [STAG-1:0] sq_tag [0:SW];
  logic [RW-1:0]   sq_rad [0:SW];
  logic [SW+1:0]   sq_rem [0:SW];
  logic [SW-1:0]   sq_root[0:SW];

  assign sq_v[0]    = s2_v_r;
  assign sq_tag[0]  = s2_tag_r;
  assign sq_rad[0]  = s2_rad_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    qrs_sqrt_cell #(.SW(SW), .TAG_W(STAG)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .v_i    (sq_v[i]),
      .tag_i  (sq_tag[i]),
      .rad_i  (sq_rad[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .v_o    (sq_v[i+1]),
      .tag_o  (sq_tag[i+1]),
      .rad_o  (sq_rad[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1])
    );
  end

  // Stage three: the two numerators, their signs and magnitudes.
  logic            t_go;
  logic            t_unit;
  logic [W-1:0]    t_fb;
  logic [W-1:0]    t_b;
  logic            t_aneg;
  logic [DW-1:0]   t_den;
  logic [W+1:0]    nb;
  logic [W+1:0]    n1;
  logic [W+1:0]    n2;
  logic [W+1:0]    m1;
  logic [W+1:0]    m2;

  always_comb begin
    {t_go, t_unit, t_fb, t_b, t_aneg, t_den} = sq_tag[SW];
    nb = -{{2{t_b[W-1]}}, t_b};
    n1 = nb - {1'b0, sq_root[SW]};
    n2 = nb + {1'b0, sq_root[SW]};
    m1 = n1[W+1] ? -n1 : n1;
    m2 = n2[W+1] ? -n2 : n2;
  end

  logic            s3_v_r;
  logic [DTAG-1:0] s3_tag_r;
  logic [DW-1:0]   s3_den_r;
  logic [NW-1:0]   s3_num1_r;
  logic [NW-1:0]   s3_num2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= sq_v[SW];
    end
  end

  always_ff @(posedge clk) begin
    s3_tag_r  <= {t_go, t_unit, t_fb, n1[W+1] != t_aneg, n2[W+1] != t_aneg};
    s3_den_r  <= t_den;
    s3_num1_r <= {m1, {FRAC_BITS{1'b0}}};
    s3_num2_r <= {m2, {FRAC_BITS{1'b0}}};
  end

  // Divider chain shared by both roots.
  logic            dv_v   [0:NW];
  logic [DTAG-1:0] dv_tag [0:NW];
  logic [DW-1:0]   dv_den [0:NW];
  logic [NW-1:0]   dv_num1[0:NW];
  logic [DW-1:0]   dv_rem1[0:NW];
  logic [NW-1:0]   dv_num2[0:NW];
  logic [DW-1:0]   dv_rem2[0:NW];

  assign dv_v[0]    = s3_v_r;
  assign dv_tag[0]  = s3_tag_r;
  assign dv_den[0]  = s3_den_r;
  assign dv_num1[0] = s3_num1_r;
  assign dv_rem1[0] = '0;
  assign dv_num2[0] = s3_num2_r;
  assign dv_rem2[0] = '0;

  for (genvar j = 0; j < NW; j++) begin : g_div
    qrs_div_cell #(.DW(DW), .NW(NW), .TAG_W(DTAG)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .v_i    (dv_v[j]),
      .tag_i  (dv_tag[j]),
      .den_i  (dv_den[j]),
      .num1_i (dv_num1[j]),
      .rem1_i (dv_rem1[j]),
      .num2_i (dv_num2[j]),
      .rem2_i (dv_rem2[j]),
      .v_o    (dv_v[j+1]),
      .tag_o  (dv_tag[j+1]),
      .den_o  (dv_den[j+1]),
      .num1_o (dv_num1[j+1]),
      .rem1_o (dv_rem1[j+1]),
      .num2_o (dv_num2[j+1]),
      .rem2_o (dv_rem2[j+1])
    );
  end

  // Final stage: saturate, test both roots and pick the answer.
  logic               f_go;
  logic               f_unit;
  logic [W-1:0]       f_fb;
  logic               f_neg1;
  logic               f_neg2;
  logic [NW-1:0]      lim1;
  logic [NW-1:0]      lim2;
  logic [W-1:0]       sat1;
  logic [W-1:0]       sat2;
  logic signed [W-1:0] u1;
  logic signed [W-1:0] u2;
  logic signed [W-1:0] one_q;
  logic               q1;
  logic               q2;
  logic signed [W-1:0] pick;

  always_comb begin
    {f_go, f_unit, f_fb, f_neg1, f_neg2} = dv_tag[NW];
    lim1  = f_neg1 ? (NW'(1) << (W-1)) : ((NW'(1) << (W-1)) - 1'b1);
    lim2  = f_neg2 ? (NW'(1) << (W-1)) : ((NW'(1) << (W-1)) - 1'b1);
    sat1  = (dv_num1[NW] > lim1) ? lim1[W-1:0] : dv_num1[NW][W-1:0];
    sat2  = (dv_num2[NW] > lim2) ? lim2[W-1:0] : dv_num2[NW][W-1:0];
    u1    = f_neg1 ? -sat1 : sat1;
    u2    = f_neg2 ? -sat2 : sat2;
    one_q = W'(1) << FRAC_BITS;
    q1    = (u1 > 0) && (!f_unit || (u1 < one_q));
    q2    = (u2 > 0) && (!f_unit || (u2 < one_q));
    pick  = f_fb;
    if (f_go && q1) begin
      pick = u1;
    end
    if (f_go && q2) begin
      pick = u2;
    end
  end

  // Result register, shown for one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_v[NW];
    end
  end

  always_ff @(posedge clk) begin
    out_root_value <= pick;
    out_ok         <= f_go && (pick > 0);
  end

endmodule

// File: hdl/qrs_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per beat.
module qrs_sqrt_cell #(
  parameter int SW    = 33,
  parameter int TAG_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              v_i,
  input  logic [TAG_W-1:0]  tag_i,
  input  logic [2*SW-1:0]   rad_i,
  input  logic [SW+1:0]     rem_i,
  input  logic [SW-1:0]     root_i,
  output logic              v_o,
  output logic [TAG_W-1:0]  tag_o,
  output logic [2*SW-1:0]   rad_o,
  output logic [SW+1:0]     rem_o,
  output logic [SW-1:0]     root_o
);

  localparam int RW = 2 * SW;
  localparam int MW = SW + 2;

  logic [MW+1:0] cur;
  logic [MW+1:0] trial;
  logic          fits;
  logic [MW+1:0] diff;

  // Bring down the next two radicand bits and try a one in this position.
  always_comb begin
    cur   = {rem_i, rad_i[RW-1:RW-2]};
    trial = {{(MW-SW){1'b0}}, root_i, 2'b01};
    fits  = (cur >= trial);
    diff  = cur - trial;
  end

  // Valid bit of the beat in this cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o <= 1'b0;
    end else begin
      v_o <= v_i;
    end
  end

  // Partial root, remainder and side data move one cell on.
  always_ff @(posedge clk) begin
    tag_o  <= tag_i;
    rad_o  <= {rad_i[RW-3:0], 2'b00};
    rem_o  <= fits ? diff[MW-1:0] : cur[MW-1:0];
    root_o <= {root_i[SW-2:0], fits};
  end

endmodule

// File: hdl/qrs_div_cell.sv
// One cell of the dual divider chain: one quotient bit of both roots per beat.
module qrs_div_cell #(
  parameter int DW    = 33,
  parameter int NW    = 50,
  parameter int TAG_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              v_i,
  input  logic [TAG_W-1:0]  tag_i,
  input  logic [DW-1:0]     den_i,
  input  logic [NW-1:0]     num1_i,
  input  logic [DW-1:0]     rem1_i,
  input  logic [NW-1:0]     num2_i,
  input  logic [DW-1:0]     rem2_i,
  output logic              v_o,
  output logic [TAG_W-1:0]  tag_o,
  output logic [DW-1:0]     den_o,
  output logic [NW-1:0]     num1_o,
  output logic [DW-1:0]     rem1_o,
  output logic [NW-1:0]     num2_o,
  output logic [DW-1:0]     rem2_o
);

  logic [DW:0] cur1;
  logic [DW:0] cur2;
  logic [DW:0] den_x;
  logic        fit1;
  logic        fit2;
  logic [DW:0] sub1;
  logic [DW:0] sub2;

  // Restoring step on both numerators against the shared divisor.
  always_comb begin
    den_x = {1'b0, den_i};
    cur1  = {rem1_i, num1_i[NW-1]};
    cur2  = {rem2_i, num2_i[NW-1]};
    fit1  = (cur1 >= den_x);
    fit2  = (cur2 >= den_x);
    sub1  = cur1 - den_x;
    sub2  = cur2 - den_x;
  end

  // Valid bit of the beat in this cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o <= 1'b0;
    end else begin
      v_o <= v_i;
    end
  end

  // Quotient bits shift in where numerator bits shift out.
  always_ff @(posedge clk) begin
    tag_o  <= tag_i;
    den_o  <= den_i;
    num1_o <= {num1_i[NW-2:0], fit1};
    num2_o <= {num2_i[NW-2:0], fit2};
    rem1_o <= fit1 ? sub1[DW-1:0] : cur1[DW-1:0];
    rem2_o <= fit2 ? sub2[DW-1:0] : cur2[DW-1:0];
  end

endmodule

// File: dv/tb_quadratic_root_select.sv
// Testbench for the quadratic root selector: scoreboard, stimulus and checks.
`timescale 1ns / 1ps

// Scoreboard: predicts the root and success flag of each beat and checks results.
class root_scoreboard;
  localparam int WB = qrs_pkg::QRS_WORD_BITS;
  localparam int FB = qrs_pkg::QRS_FRAC_BITS;

  typedef struct {
    logic signed [WB-1:0] root;
    logic                 ok;
  } root_result_t;

  root_result_t pending_roots[$];
  int errors;

  // Truncated, saturated quotient (n << FB) / (2a).
  function automatic logic signed [WB-1:0] divide_root(
      logic signed [2*WB+3:0] num, logic signed [WB-1:0] a);
    logic signed [2*WB+FB+7:0] q;
    logic signed [2*WB+FB+7:0] hi_lim;
    logic signed [2*WB+FB+7:0] lo_lim;
    q = (2*WB+FB+8)'(num <<< FB) / ((2*WB+FB+8)'(a) * 2);
    hi_lim = (2*WB+FB+8)'((64'sd1 <<< (WB-1)) - 1);
    lo_lim = -(2*WB+FB+8)'(64'sd1 <<< (WB-1));
    if (q > hi_lim) q = hi_lim;
    if (q < lo_lim) q = lo_lim;
    return q[WB-1:0];
  endfunction

  function automatic bit root_fits(logic signed [WB-1:0] u, bit unit_mode);
    if (unit_mode) return u > 0 && u < (1 <<< FB);
    return u > 0;
  endfunction

  // Note one accepted beat and queue its expected result.
  function void note_beat(logic signed [WB-1:0] a, logic signed [WB-1:0] b,
                          logic signed [WB-1:0] c, bit unit_mode,
                          logic signed [WB-1:0] fallback);
    logic signed [2*WB+3:0] disc;
    logic [2*WB+3:0] s;
    logic [2*WB+3:0] cand;
    logic signed [WB-1:0] u1;
    logic signed [WB-1:0] u2;
    root_result_t r;
    r.root = fallback;
    r.ok = 1'b0;
    if (a != 0) begin
      disc = (2*WB+4)'(b) * b - 4 * (2*WB+4)'(a) * c;
      if (disc > 0) begin
        s = 0;
        for (int i = WB + 1; i >= 0; i--) begin
          cand = s | ((2*WB+4)'(1) << i);
          if (cand * cand <= disc) s = cand;
        end
        u1 = divide_root(-(2*WB+4)'(b) - $signed(s), a);
        u2 = divide_root(-(2*WB+4)'(b) + $signed(s), a);
        if (root_fits(u1, unit_mode)) r.root = u1;
        if (root_fits(u2, unit_mode)) r.root = u2;
        r.ok = r.root > 0;
      end
    end
    pending_roots.push_back(r);
  endfunction

  // Compare one result beat with the oldest expectation.
  function void check_result(logic signed [WB-1:0] root, logic ok);
    root_result_t e;
    if (pending_roots.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result root=%0d ok=%0b", root, ok);
      return;
    end
    e = pending_roots.pop_front();
    if (root !== e.root || ok !== e.ok) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected root=%0d ok=%0b, got root=%0d ok=%0b",
                 e.root, e.ok, root, ok);
    end
  endfunction
endclass

module tb_quadratic_root_select;
  import qrs_pkg::*;

  localparam int WB = QRS_WORD_BITS;
  localparam int FB = QRS_FRAC_BITS;
  localparam int LATENCY = 2*WB + FB + 7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [WB-1:0] in_coef_quad = '0;
  logic signed [WB-1:0] in_coef_lin = '0;
  logic signed [WB-1:0] in_coef_const = '0;
  logic in_unit_interval_mode = 1'b0;
  logic signed [WB-1:0] in_fallback_root = '0;
  logic out_valid;
  logic signed [WB-1:0] out_root_value;
  logic out_ok;

  root_scoreboard roots = new();
  bit calm_stretch = 1'b0;

  quadratic_root_select dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample handshakes at the rising edge.
  always @(posedge clk) begin
    if (rst_n && start && !busy)
      roots.note_beat(in_coef_quad, in_coef_lin, in_coef_const,
                      in_unit_interval_mode, in_fallback_root);
    if (rst_n && out_valid) roots.check_result(out_root_value, out_ok);
  end

  // Present one beat and hold it until taken; random gaps before it.
  task automatic send_beat(logic signed [WB-1:0] a, logic signed [WB-1:0] b,
                           logic signed [WB-1:0] c, bit unit_mode,
                           logic signed [WB-1:0] fallback);
    while (!calm_stretch && $urandom_range(99) < 7) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_coef_quad <= a;
    in_coef_lin <= b;
    in_coef_const <= c;
    in_unit_interval_mode <= unit_mode;
    in_fallback_root <= fallback;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Random word biased toward small Q16.16 values so that roots qualify.
  function automatic logic signed [WB-1:0] pick_word();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed(WB'($urandom_range(4 << FB))) - (2 << FB);
      2: return $signed(WB'($urandom_range(1 << 20))) - (1 << 19);
      default: return $signed(WB'($urandom_range(64 << FB))) - (32 << FB);
    endcase
  endfunction

  localparam logic signed [WB-1:0] MAX_W = {1'b0, {(WB-1){1'b1}}};
  localparam logic signed [WB-1:0] MIN_W = {1'b1, {(WB-1){1'b0}}};
  localparam logic signed [WB-1:0] ONE = 1 <<< FB;

  initial begin
    logic signed [WB-1:0] r0;
    logic signed [WB-1:0] r1;
    logic signed [WB-1:0] a;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed beats: zero a, nonpositive discriminant, extremes, both modes.
    send_beat('0, ONE, ONE, 1'b0, ONE);
    send_beat('0, '0, '0, 1'b1, -ONE);
    send_beat(ONE, '0, ONE, 1'b0, ONE);
    send_beat(ONE, 2 * ONE, ONE, 1'b0, 5);
    send_beat(ONE, -3 * ONE / 2, ONE / 2, 1'b1, ONE);
    send_beat(ONE, -3 * ONE / 2, ONE / 2, 1'b0, ONE);
    send_beat(ONE, -3 * ONE, 2 * ONE, 1'b0, -ONE);
    send_beat(-ONE, '0, ONE / 4, 1'b1, '0);
    send_beat(ONE, ONE, -2 * ONE, 1'b0, MIN_W);
    send_beat(MAX_W, MAX_W, MAX_W, 1'b0, MAX_W);
    send_beat(MIN_W, MIN_W, MIN_W, 1'b1, MIN_W);
    send_beat(MAX_W, MIN_W, MIN_W, 1'b0, -1);
    send_beat(MIN_W, MAX_W, MAX_W, 1'b1, 1);
    send_beat(1, MAX_W, '0, 1'b0, '0);
    send_beat(1, MIN_W, -1, 1'b0, '0);
    send_beat(-1, MAX_W, 1, 1'b1, 1);
    send_beat(1, '0, MIN_W, 1'b0, ONE);
    send_beat('1, 1, 1, 1'b1, '1);
    send_beat(ONE, ONE, ONE / 8, 1'b1, -5);

    // Hold off until every expected result has arrived.
    start <= 1'b0;
    while (roots.pending_roots.size() != 0) @(negedge clk);

    // Random beats; mostly built from chosen roots so that selection is exercised.
    for (int n = 0; n < 1000; n++) begin
      calm_stretch = (n >= 400 && n < 550);
      if ($urandom_range(99) < 60) begin
        r0 = $signed(WB'($urandom_range(3 << FB))) - (1 << FB);
        r1 = $signed(WB'($urandom_range(3 << FB))) - (1 << FB);
        a = $signed(WB'($urandom_range(2 << FB))) - (1 << FB);
        if (a == 0) a = ONE;
        send_beat(a, WB'(-((64'(a) * (r0 + r1)) >>> FB)),
                  WB'((((64'(a) * r0) >>> FB) * r1) >>> FB), 1'($urandom_range(1)),
                  pick_word());
      end else begin
        send_beat(pick_word(), pick_word(), pick_word(), 1'($urandom_range(1)),
                  pick_word());
      end
    end
    start <= 1'b0;

    while (roots.pending_roots.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (roots.errors == 0) begin
      $display("tb_quadratic_root_select passed");
    end else begin
      $display("tb_quadratic_root_select failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("tb_quadratic_root_select failed");
    $finish;
  end
endmodule
